// ===== sv/mhs_pkg.sv =====
// Package for the streaming MurmurHash2 block: constants, queue entry type
// and the shared multiply and tail-mask helpers. No dependencies.
package mhs_pkg;

    localparam logic [31:0] MHS_MIX_MUL     = 32'h5bd1_e995;
    localparam int          MHS_MIX_SHIFT   = 24;
    localparam int          MHS_FIN_SHIFT_A = 13;
    localparam int          MHS_FIN_SHIFT_B = 15;
    localparam int          MHS_QUEUE_DEPTH = 4;
    localparam int          MHS_LEN_W       = 31;
    localparam int          MHS_WORD_W      = 32;
    localparam int          MHS_BV_W        = 3;

    // What the back end does with one item's data
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_FULL,
        KIND_TAIL
    } t_mhs_kind;

    typedef struct packed {
        t_mhs_kind              kind;
        logic                   first;
        logic                   last;
        logic [MHS_LEN_W-1:0]   length;
        logic [MHS_WORD_W-1:0]  value;  // mixed word (full) or masked tail
    } t_mhs_op;

    // Multiply by the mixing constant, modulo 2^32
    function automatic logic [31:0] mhs_mul(input logic [31:0] x);
        logic [31:0] p;
        p = x * MHS_MIX_MUL;
        return p;
    endfunction

    // Keep the low 1 to 3 bytes of a tail word
    function automatic logic [31:0] mhs_tail_mask(input logic [1:0] nbytes);
        logic [31:0] m;
        case (nbytes)
            2'd1:    m = 32'h0000_00ff;
            2'd2:    m = 32'h0000_ffff;
            2'd3:    m = 32'h00ff_ffff;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/mhs_front.sv =====
// Front end: accepts key items, classifies them and mixes full words in two
// multiply stages. Depends on mhs_pkg.
module mhs_front
    import mhs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_first_item,
    input  logic                  i_last_item,
    input  logic [MHS_LEN_W-1:0]  i_total_length,
    input  logic [MHS_WORD_W-1:0] i_data_word,
    input  logic [MHS_BV_W-1:0]   i_bytes_valid,
    output logic                  o_q_push,
    output t_mhs_op               o_q_entry,
    input  logic                  i_q_full
);

    logic                  r_s1_valid;
    logic                  r_s1_first;
    logic                  r_s1_last;
    logic [MHS_LEN_W-1:0]  r_s1_length;
    logic [MHS_WORD_W-1:0] r_s1_word;
    logic [MHS_BV_W-1:0]   r_s1_bv;
    logic [31:0]           r_s1_prod;

    logic                  r_s2_valid;
    t_mhs_op               r_s2_entry;

    logic                  s1_adv;
    logic                  s2_adv;
    logic                  in_xfer;
    logic [31:0]           s1_shx;
    t_mhs_op               n_s2_entry;

    assign s2_adv  = !r_s2_valid || !i_q_full;
    assign s1_adv  = !r_s1_valid || s2_adv;
    assign full    = !s1_adv;
    assign in_xfer = push && s1_adv;

    assign o_q_push  = r_s2_valid && !i_q_full;
    assign o_q_entry = r_s2_entry;

    assign s1_shx = r_s1_prod ^ (r_s1_prod >> MHS_MIX_SHIFT);

    always_comb begin
        n_s2_entry.first  = r_s1_first;
        n_s2_entry.last   = r_s1_last;
        n_s2_entry.length = r_s1_length;
        if (r_s1_bv == '0) begin
            n_s2_entry.kind  = KIND_NONE;
            n_s2_entry.value = r_s1_word;
        end else if (r_s1_bv inside {3'd4, 3'd5, 3'd6, 3'd7}) begin
            // four or more bytes count as a full word
            n_s2_entry.kind  = KIND_FULL;
            n_s2_entry.value = mhs_mul(s1_shx);
        end else begin
            n_s2_entry.kind  = KIND_TAIL;
            n_s2_entry.value = r_s1_word & mhs_tail_mask(r_s1_bv[1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= push;
            end
            if (s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
        end
        if (in_xfer) begin
            r_s1_first  <= i_first_item;
            r_s1_last   <= i_last_item;
            r_s1_length <= i_total_length;
            r_s1_word   <= i_data_word;
            r_s1_bv     <= i_bytes_valid;
            r_s1_prod   <= mhs_mul(i_data_word);
        end
        if (s2_adv && r_s1_valid) begin
            r_s2_entry <= n_s2_entry;
        end
    end

`ifndef SYNTHESIS
    // A stalled second stage keeps its entry
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && i_q_full) |=> (r_s2_valid && $stable(r_s2_entry)))
        else $error("front stage 2 lost or changed a stalled entry");
`endif

endmodule

// ===== sv/mhs_fifo.sv =====
// Short queue of classified items between front and back end.
// Depends on mhs_pkg for the entry type.
module mhs_fifo
    import mhs_pkg::*;
#(
    parameter int DEPTH = MHS_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr_en,
    input  t_mhs_op i_wr_data,
    output logic    o_full,
    input  logic    i_rd_en,
    output t_mhs_op o_rd_data,
    output logic    o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_mhs_op            r_slot [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_wr;
    logic               do_rd;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr_en && !o_full;
    assign do_rd     = i_rd_en && !o_empty;
    assign o_rd_data = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_wr) begin
            r_slot[r_wr_ptr] <= i_wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");
`endif

endmodule

// ===== sv/mhs_back.sv =====
// Back end: running-hash recurrence, final avalanche and result register.
// Depends on mhs_pkg.
module mhs_back
    import mhs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [31:0]           i_hash_seed,
    input  logic                  i_q_empty,
    input  t_mhs_op               i_q_entry,
    output logic                  o_q_pop,
    output logic                  empty,
    input  logic                  pop,
    output logic [MHS_WORD_W-1:0] o_hash_value
);

    typedef enum logic {
        S_STEP,
        S_AVAL
    } t_state;

    t_state      r_state;
    logic [31:0] r_hash;
    logic        r_out_valid;
    logic [31:0] r_out_hash;

    logic [31:0] h_start;
    logic [31:0] mul_in;
    logic [31:0] mul_out;
    logic [31:0] n_hash;
    logic [31:0] fin_pre;
    logic [31:0] fin_mul;
    logic        out_xfer;
    logic        out_load;

    assign empty        = !r_out_valid;
    assign o_hash_value = r_out_hash;
    assign out_xfer     = pop && r_out_valid;
    assign o_q_pop      = (r_state == S_STEP) && !i_q_empty;
    assign out_load     = (r_state == S_AVAL) && (!r_out_valid || pop);

    // at most one multiply per item: h*M ^ k for a full word, (h ^ t)*M for a tail; an empty item keeps h
    always_comb begin
        h_start = i_q_entry.first ? (i_hash_seed ^ {1'b0, i_q_entry.length}) : r_hash;
        mul_in  = (i_q_entry.kind == KIND_TAIL) ? (h_start ^ i_q_entry.value) : h_start;
        mul_out = mhs_mul(mul_in);
        case (i_q_entry.kind)
            KIND_FULL: n_hash = mul_out ^ i_q_entry.value;
            KIND_TAIL: n_hash = mul_out;
            default:   n_hash = h_start;
        endcase
    end

    assign fin_pre = r_hash ^ (r_hash >> MHS_FIN_SHIFT_A);
    assign fin_mul = mhs_mul(fin_pre);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_STEP;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_STEP: begin
                    if (out_xfer) begin
                        r_out_valid <= 1'b0;
                    end
                    if (o_q_pop) begin
                        r_hash <= n_hash;
                        if (i_q_entry.last) begin
                            r_state <= S_AVAL;
                        end
                    end
                end
                S_AVAL: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_STEP;
                    end
                end
                default: r_state <= S_STEP;
            endcase
        end
        if (out_load) begin
            r_out_hash <= fin_mul ^ (fin_mul >> MHS_FIN_SHIFT_B);
        end
    end

`ifndef SYNTHESIS
    // A waiting result is never overwritten by the next avalanche
    a_aval_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AVAL && r_out_valid && !pop) |=> (r_state == S_AVAL))
        else $error("avalanche left while result register occupied");

    // Running hash only moves when a queue entry is taken
    a_hash_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_q_pop && $past(i_rst_n)) |=> $stable(r_hash))
        else $error("running hash changed without a queue entry");
`endif

endmodule

// ===== sv/murmur2_hash_stream.sv =====
// Streaming 32-bit MurmurHash2: one key word per input transfer, one hash per key.
// A key-end hash passes the two front stages, the queue, the running-hash register and the
// result register. The front takes one transfer a cycle unless the queue holds up its second
// stage; the back takes an item in S_STEP and, after an item that ends a key, goes through S_AVAL.
// Reset (synchronous, i_rst_n low): pipeline, queue and result emptied, seed and
// running hash cleared to zero. Depends on mhs_pkg, mhs_front, mhs_fifo, mhs_back.
module murmur2_hash_stream
    import mhs_pkg::*;
#(
    parameter int QUEUE_DEPTH = MHS_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration: seed register, write-only
    input  logic                  i_cfg_wr_en,
    input  logic [31:0]           i_cfg_wr_data,
    // input queue side
    input  logic                  push,
    output logic                  full,
    input  logic                  i_first_item,
    input  logic                  i_last_item,
    input  logic [MHS_LEN_W-1:0]  i_total_length,
    input  logic [MHS_WORD_W-1:0] i_data_word,
    input  logic [MHS_BV_W-1:0]   i_bytes_valid,
    // result queue side
    output logic                  empty,
    input  logic                  pop,
    output logic [MHS_WORD_W-1:0] o_hash_value
);

    // Seed register; the user must write it only while the block is idle, a rule the block leaves unchecked
    logic [31:0] r_hash_seed;

    // front -> queue
    logic        f_push;
    t_mhs_op     f_entry;
    logic        q_full;
    // queue -> back
    logic        b_pop;
    t_mhs_op     q_entry;
    logic        q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_seed <= '0;
        end else if (i_cfg_wr_en) begin
            r_hash_seed <= i_cfg_wr_data;
        end
    end

    // Front: classify the item, mix full words (two multiply stages)
    mhs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_first_item   (i_first_item),
        .i_last_item    (i_last_item),
        .i_total_length (i_total_length),
        .i_data_word    (i_data_word),
        .i_bytes_valid  (i_bytes_valid),
        .o_q_push       (f_push),
        .o_q_entry      (f_entry),
        .i_q_full       (q_full)
    );

    // Decoupling queue: lets the front keep mixing while the back finishes a key
    mhs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (f_push),
        .i_wr_data (f_entry),
        .o_full    (q_full),
        .i_rd_en   (b_pop),
        .o_rd_data (q_entry),
        .o_empty   (q_empty)
    );

    // Back: running hash, avalanche, result register
    mhs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hash_seed  (r_hash_seed),
        .i_q_empty    (q_empty),
        .i_q_entry    (q_entry),
        .o_q_pop      (b_pop),
        .empty        (empty),
        .pop          (pop),
        .o_hash_value (o_hash_value)
    );

endmodule

// ===== test/murmur2_hash_stream_tb.sv =====
// Self-checking testbench for murmur2_hash_stream: directed, seed, random and back-pressure runs.
// It holds its own model of the block and checks every hash that leaves the result queue.
// Depends on mhs_pkg and murmur2_hash_stream.
module murmur2_hash_stream_tb
    import mhs_pkg::*;
();

    // Extra cycles after the last expected hash: covers items still in flight
    // that end no key (the front stages and a queue of 4).
    localparam int DRAIN_CYCLES    = 16;
    // Long receiver hold-off for the back-pressure run
    localparam int HOLD_OFF_CYCLES = 150;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [31:0]           i_cfg_wr_data;
    logic                  push;
    logic                  full;
    logic                  i_first_item;
    logic                  i_last_item;
    logic [MHS_LEN_W-1:0]  i_total_length;
    logic [MHS_WORD_W-1:0] i_data_word;
    logic [MHS_BV_W-1:0]   i_bytes_valid;
    logic                  empty;
    logic                  pop;
    logic [MHS_WORD_W-1:0] o_hash_value;

    // Model state: seed register and running hash before the avalanche
    logic [31:0]           seed_model;
    logic [31:0]           running_model;
    // Finished hashes still to come out of the block, oldest first
    logic [31:0]           hash_expect_q[$];
    logic [31:0]           hash_want;

    int unsigned           mismatch_count = 0;
    int unsigned           items_accepted = 0;
    // Chance in percent of an idle burst before a transfer, per side
    int unsigned           src_idle_pct   = 0;
    int unsigned           sink_idle_pct  = 0;
    // Long hold-off request to the receiver, and its acknowledgement
    bit                    sink_hold_req  = 1'b0;
    bit                    sink_holding   = 1'b0;

    murmur2_hash_stream i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .push           (push),
        .full           (full),
        .i_first_item   (i_first_item),
        .i_last_item    (i_last_item),
        .i_total_length (i_total_length),
        .i_data_word    (i_data_word),
        .i_bytes_valid  (i_bytes_valid),
        .empty          (empty),
        .pop            (pop),
        .o_hash_value   (o_hash_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Fold one accepted item into the model; a key end queues the finished hash.
    // Byte counts above four saturate to a full word; a partial word is always
    // taken as a tail, last item or not.
    task automatic fold_into_model(input bit first, input bit last,
                                   input logic [MHS_LEN_W-1:0] len,
                                   input logic [31:0] word,
                                   input logic [MHS_BV_W-1:0] nbytes);
        logic [31:0] k;
        logic [31:0] h;
        int unsigned n;
        n = (nbytes > 4) ? 4 : nbytes;
        if (first)
            running_model = seed_model ^ {1'b0, len};
        if (n == 4) begin
            k = word * MHS_MIX_MUL;
            k = k ^ (k >> MHS_MIX_SHIFT);
            k = k * MHS_MIX_MUL;
            running_model = (running_model * MHS_MIX_MUL) ^ k;
        end else if (n != 0) begin
            // bytes at or above the count are dropped
            k = word & ((32'h1 << (8 * n)) - 32'h1);
            running_model = (running_model ^ k) * MHS_MIX_MUL;
        end
        if (last) begin
            // avalanche works on a copy; the running hash carries on unchanged
            h = running_model ^ (running_model >> MHS_FIN_SHIFT_A);
            h = h * MHS_MIX_MUL;
            h = h ^ (h >> MHS_FIN_SHIFT_B);
            hash_expect_q.push_back(h);
        end
    endtask

    // Offer one item and hold it until the block takes it. Called at a rising
    // edge; returns at the edge of the transfer with push still high, so the
    // next call can drive the following item in the same step.
    task automatic send_item(input bit first, input bit last,
                             input logic [MHS_LEN_W-1:0] len,
                             input logic [31:0] word,
                             input logic [MHS_BV_W-1:0] nbytes);
        bit taken;
        if (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(11, 1)) @(posedge i_clk);
        end
        push           <= 1'b1;
        i_first_item   <= first;
        i_last_item    <= last;
        i_total_length <= len;
        i_data_word    <= word;
        i_bytes_valid  <= nbytes;
        taken = 1'b0;
        // full is sampled mid-cycle, clear of the edge
        while (!taken) begin
            @(negedge i_clk);
            taken = !full;
            @(posedge i_clk);
        end
        fold_into_model(first, last, len, word, nbytes);
        items_accepted++;
    endtask

    // Stop offering, wait for every expected hash, then let the pipeline empty
    task automatic wait_for_drain();
        push <= 1'b0;
        while (hash_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Seed register is only written with the block idle
    task automatic write_seed(input logic [31:0] value);
        wait_for_drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        seed_model = value;
    endtask

    // One key of random content: mostly well-formed (full words then a tail
    // on the last item), some with a declared length that does not match,
    // and some lone unconstrained items that break up the key structure.
    task automatic send_random_key();
        int unsigned          pick;
        int unsigned          key_bytes;
        int unsigned          n_items;
        int unsigned          i;
        logic [MHS_LEN_W-1:0] declared;
        logic [MHS_BV_W-1:0]  nb;
        pick = $urandom_range(99, 0);
        if (pick < 15) begin
            send_item(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                      MHS_LEN_W'($urandom), $urandom, MHS_BV_W'($urandom_range(7, 0)));
        end else begin
            key_bytes = (pick < 90) ? $urandom_range(40, 0) : $urandom_range(160, 41);
            declared  = (pick >= 95) ? MHS_LEN_W'($urandom) : MHS_LEN_W'(key_bytes);
            n_items   = (key_bytes == 0) ? 1 : (key_bytes + 3) / 4;
            for (i = 0; i < n_items; i++) begin
                nb = (key_bytes - 4 * i >= 4) ? MHS_BV_W'(4) : MHS_BV_W'(key_bytes - 4 * i);
                // length field only matters on the first item; junk elsewhere
                send_item(i == 0, i == n_items - 1,
                          (i == 0) ? declared : MHS_LEN_W'($urandom), $urandom, nb);
            end
        end
    endtask

    // Edge cases after reset: seed and running hash both zero
    task automatic test_directed_cases();
        // key goes on from the reset state without a first item
        send_item(1'b0, 1'b1, 31'h0,        32'ha5a5_a5a5, 3'd4);
        // empty key: first and last together, no bytes, junk word ignored
        send_item(1'b1, 1'b1, 31'h0,        32'hffff_ffff, 3'd0);
        // largest length and word, then a 3-byte tail
        send_item(1'b1, 1'b0, 31'h7fff_ffff, 32'hffff_ffff, 3'd4);
        send_item(1'b0, 1'b1, 31'h7fff_ffff, 32'hffff_ffff, 3'd3);
        // item after a key end without first: continues from the running hash
        send_item(1'b0, 1'b1, 31'h0,        32'h0000_0000, 3'd4);
        // 1, 2 and 3 byte tails with junk in the unused high bytes
        send_item(1'b1, 1'b1, 31'h1,        32'h1234_5678, 3'd1);
        send_item(1'b1, 1'b1, 31'h2,        32'hffff_ffff, 3'd2);
        send_item(1'b1, 1'b1, 31'h3,        $urandom,      3'd3);
        // byte counts above four saturate to a full word
        send_item(1'b1, 1'b0, 31'hc,        $urandom,      3'd5);
        send_item(1'b0, 1'b0, 31'h0,        $urandom,      3'd6);
        send_item(1'b0, 1'b1, 31'h0,        $urandom,      3'd7);
        // partial word mid-key, then an empty item, then a full word
        send_item(1'b1, 1'b0, 31'h6,        $urandom,      3'd2);
        send_item(1'b0, 1'b0, 31'h0,        $urandom,      3'd0);
        send_item(1'b0, 1'b1, 31'h0,        $urandom,      3'd4);
        // empty last item adds no tail
        send_item(1'b1, 1'b0, 31'h4,        $urandom,      3'd4);
        send_item(1'b0, 1'b1, 31'h0,        $urandom,      3'd0);
        // first item mid-key restarts the hash
        send_item(1'b1, 1'b0, 31'h8,        32'h0000_0000, 3'd4);
        send_item(1'b1, 1'b1, 31'h5555_5555, $urandom,     3'd4);
    endtask

    // Seed register at both extremes and one random value
    task automatic test_seed_values();
        logic [31:0] seeds [3];
        int unsigned i;
        seeds[0] = 32'hffff_ffff;
        seeds[1] = 32'h0000_0000;
        seeds[2] = $urandom;
        for (i = 0; i < 3; i++) begin
            write_seed(seeds[i]);
            send_item(1'b1, 1'b1, 31'h0, $urandom, 3'd0);
            send_item(1'b1, 1'b1, 31'h7fff_ffff, $urandom, 3'd0);
            send_random_key();
        end
    endtask

    // Random keys with random idling on both sides and the odd seed change
    task automatic test_random_keys(input int unsigned n_items);
        int unsigned start_count;
        int unsigned keys;
        start_count = items_accepted;
        keys = 0;
        while (items_accepted - start_count < n_items) begin
            if (keys % 40 == 0) begin
                // some stretches run with no idling at all
                src_idle_pct  = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 10);
                sink_idle_pct = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 10);
            end
            if (keys % 60 == 59)
                write_seed($urandom);
            send_random_key();
            keys++;
        end
    endtask

    // Receiver holds off while the sender keeps offering key ends back to back,
    // so the result queue and then the input side fill up
    task automatic test_output_backpressure();
        int unsigned i;
        src_idle_pct = 0;
        push <= 1'b0;
        sink_hold_req = 1'b1;
        while (!sink_holding)
            @(posedge i_clk);
        for (i = 0; i < 24; i++)
            send_item(1'b1, 1'b1, MHS_LEN_W'($urandom), $urandom, 3'd4);
    endtask

    // Closing stretch: both sides flat out
    task automatic test_random_no_idle(input int unsigned n_items);
        int unsigned start_count;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        start_count = items_accepted;
        while (items_accepted - start_count < n_items)
            send_random_key();
    endtask

    // Result side: pop with random stall bursts, plus the long hold-off on request
    initial begin
        pop = 1'b0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            if (sink_hold_req) begin
                sink_holding = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                sink_hold_req = 1'b0;
                sink_holding  = 1'b0;
            end else if (sink_idle_pct != 0 && $urandom_range(99, 0) < sink_idle_pct) begin
                pop <= 1'b0;
                repeat ($urandom_range(11, 1)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Result check, sampled mid-cycle: a transfer happens at the next edge
    always @(negedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (hash_expect_q.size() == 0) begin
                $error("hash_value: no result expected, actual %h", o_hash_value);
                mismatch_count++;
            end else begin
                hash_want = hash_expect_q.pop_front();
                if (o_hash_value !== hash_want) begin
                    $error("hash_value: expected %h, actual %h", hash_want, o_hash_value);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        push           = 1'b0;
        i_first_item   = 1'b0;
        i_last_item    = 1'b0;
        i_total_length = '0;
        i_data_word    = '0;
        i_bytes_valid  = '0;
        seed_model     = '0;
        running_model  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_seed_values();
        test_random_keys(1100);
        test_output_backpressure();
        test_random_no_idle(300);

        wait_for_drain();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit, several times the slowest correct run
    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
